@@ hw/rtl/bht_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table package
// Shared field widths, operation and status codes, and the packed request,
// result and job types used across the bucketed hash table core.
// ----------------------------------------------------------------------------
package bht_pkg;

    // Field widths of one request and one result.
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 3;

    // Widest bucket index that the BUCKETS range can need.
    localparam int BKT_MAX_W = 10;

    // Default table geometry.
    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    // Queue depths between the parts of the core.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Operation codes carried in the action field.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    // Status codes returned with every result.
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd5;

    // One request as it arrives at the core.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } req_t;

    // One result as it leaves the core.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value_out;
        logic              table_empty;
    } rsp_t;

    // A request once the front has worked out its bucket.
    typedef struct packed {
        req_t                 req;
        logic [BKT_MAX_W-1:0] bucket;
    } job_t;

    // Status flags of a small queue.
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // Status of the back part as seen by the front.
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

@@ hw/rtl/bht_queue.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table small queue
// A register-based first-in first-out queue that decouples the parts of the
// core; it takes a push and a pop in the same cycle while it is neither full nor empty.
// ----------------------------------------------------------------------------
module bht_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output bht_pkg::qstat_t            stat,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    // A request moves only when the queue can take or give it.
    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign count      = count_reg;
    assign rdata      = data_reg[rd_ptr_reg];

    // Pointer and fill count updates, with wrap at the last entry.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/bht_front.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table front
// Accepts requests and works out each key's bucket as key modulo BUCKETS by
// a reciprocal multiply and one correction step, over two pipeline stages.
// ----------------------------------------------------------------------------
module bht_front #(
    parameter int BUCKETS   = bht_pkg::BUCKETS_DEF,
    parameter int MID_DEPTH = bht_pkg::MID_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  bht_pkg::req_t                  req,
    input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
    input  bht_pkg::back_stat_t            back_stat,
    output logic                           mid_push,
    output bht_pkg::job_t                  mid_job
);

    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int RW        = BKT_W + 1;
    localparam int BKT_SHIFT = 30 + BKT_W;
    localparam int RECIP_W   = 32;
    localparam int PROD_W    = bht_pkg::KEY_W + RECIP_W;
    localparam int CNT_W     = $clog2(MID_DEPTH + 1);
    localparam logic [RECIP_W-1:0] BKT_RECIP = RECIP_W'((64'd1 << BKT_SHIFT) / BUCKETS);
    localparam logic [RW-1:0]      BKT_MOD   = RW'(BUCKETS);

    logic              accept;
    logic              s1v_reg;
    logic              s2v_reg;
    bht_pkg::req_t     s1_req_reg;
    bht_pkg::req_t     s2_req_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [RW-1:0]     s2_qb_reg;
    logic [RW-1:0]     q_low;
    logic [RW-1:0]     rem_raw;
    logic [RW-1:0]     rem_fix;
    logic [CNT_W:0]    load;

    // Requests in the pipeline hold a place in the queue ahead of them, so the
    // pipeline never has to stall.
    assign load = (CNT_W+1)'(mid_count) + (CNT_W+1)'(s1v_reg) + (CNT_W+1)'(s2v_reg);
    assign full = back_stat.clearing || (load >= (CNT_W+1)'(MID_DEPTH));
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
        end
        else
        begin
            s1v_reg <= accept;
            s2v_reg <= s1v_reg;
        end
    end

    // The estimated quotient falls short by at most one, and only its low bits
    // are needed since the remainder stays below twice BUCKETS.
    assign q_low = s1_prod_reg[BKT_SHIFT +: RW];

    always_ff @(posedge clk)
    begin
        s1_req_reg  <= req;
        s1_prod_reg <= PROD_W'(req.key) * PROD_W'(BKT_RECIP);
        s2_req_reg  <= s1_req_reg;
        s2_qb_reg   <= q_low * BKT_MOD;
    end

    // Remainder with its single correction step.
    assign rem_raw = s2_req_reg.key[RW-1:0] - s2_qb_reg;
    assign rem_fix = (rem_raw >= BKT_MOD) ? rem_raw - BKT_MOD : rem_raw;

    assign mid_push       = s2v_reg;
    assign mid_job.req    = s2_req_reg;
    assign mid_job.bucket = bht_pkg::BKT_MAX_W'(rem_fix);

endmodule

@@ hw/rtl/bht_back.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table back
// Holds the table as one row per bucket and clears its valid bits after reset.
// For each request it reads a bucket's ways, then compares them against the key
// and writes the row back before it takes the next request.
module bht_back #(
    parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
    parameter int WAYS    = bht_pkg::WAYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bht_pkg::job_t       mid_job,
    input  bht_pkg::qstat_t     mid_stat,
    output logic                mid_pop,
    input  bht_pkg::qstat_t     out_stat,
    output logic                out_push,
    output bht_pkg::rsp_t       out_rsp,
    output bht_pkg::back_stat_t back_stat
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W = bht_pkg::KEY_W;
    localparam int VAL_W = bht_pkg::VAL_W;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    // Bucket rows: valid bits, keys and values of all ways.
    logic [WAYS-1:0]       valid_mem [BUCKETS];
    logic [WAYS*KEY_W-1:0] key_mem   [BUCKETS];
    logic [WAYS*VAL_W-1:0] val_mem   [BUCKETS];

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [BKT_W-1:0]      clr_idx_reg;
    logic [BKT_W-1:0]      clr_idx_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    bht_pkg::job_t         job_reg;

    logic                  rd_en;
    logic [BKT_W-1:0]      rd_addr;
    logic [WAYS-1:0]       rd_valid_reg;
    logic [WAYS*KEY_W-1:0] rd_key_reg;
    logic [WAYS*VAL_W-1:0] rd_val_reg;

    logic                  mem_wr;
    logic                  kv_wr;
    logic [BKT_W-1:0]      wr_addr;
    logic [WAYS-1:0]       wr_valid;
    logic [WAYS*KEY_W-1:0] wr_key;
    logic [WAYS*VAL_W-1:0] wr_val;

    logic                  start;
    logic [WAYS-1:0]       hit_vec;
    logic [WAYS-1:0]       hit_oh;
    logic [WAYS-1:0]       free_vec;
    logic [WAYS-1:0]       free_oh;
    logic [WAYS-1:0]       set_oh;
    logic [WAYS-1:0]       load_oh;
    logic [WAYS-1:0]       drop_oh;
    logic                  any_hit;
    logic                  any_free;
    logic [VAL_W-1:0]      hit_val;
    logic [bht_pkg::STAT_W-1:0] status;

    // A new request starts only when the result queue has room for it.
    assign start    = (state_reg == S_READ) && !mid_stat.empty && !out_stat.full;
    assign mid_pop  = start;
    assign rd_en    = start;
    assign rd_addr  = mid_job.bucket[BKT_W-1:0];
    assign back_stat.clearing = (state_reg == S_CLEAR);

    // Way compare and lowest-way selection.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = rd_valid_reg[w] &&
                         (rd_key_reg[w*KEY_W +: KEY_W] == job_reg.req.key);
        end
        free_vec = ~rd_valid_reg;
        hit_oh   = hit_vec & (~hit_vec + WAYS'(1));
        free_oh  = free_vec & (~free_vec + WAYS'(1));
        any_hit  = |hit_vec;
        any_free = |free_vec;
        hit_val  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_val = hit_val | (rd_val_reg[w*VAL_W +: VAL_W] & {VAL_W{hit_oh[w]}});
        end
    end

    // Decide the outcome of the request and the changes to its bucket row.
    always_comb
    begin
        status     = bht_pkg::STAT_NOTFOUND;
        set_oh     = '0;
        load_oh    = '0;
        drop_oh    = '0;
        count_next = count_reg;
        case (job_reg.req.action)
            bht_pkg::ACT_INSERT:
            begin
                if (any_hit)
                begin
                    status = bht_pkg::STAT_REPLACED;
                    load_oh = hit_oh;
                end
                else if (any_free)
                begin
                    status     = bht_pkg::STAT_INSERTED;
                    set_oh     = free_oh;
                    load_oh    = free_oh;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    status = bht_pkg::STAT_FULL;
                end
            end
            bht_pkg::ACT_REMOVE:
            begin
                if (any_hit)
                begin
                    status  = bht_pkg::STAT_REMOVED;
                    drop_oh = hit_oh;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            bht_pkg::ACT_LOOKUP:
            begin
                if (any_hit)
                begin
                    status = bht_pkg::STAT_FOUND;
                end
            end
            default:
            begin
                status = bht_pkg::STAT_NOTFOUND;
            end
        endcase
    end

    // Result of the request in the update cycle.
    assign out_push              = (state_reg == S_UPDATE);
    assign out_rsp.status        = status;
    assign out_rsp.value_out     = (status == bht_pkg::STAT_FOUND) ? hit_val : '0;
    assign out_rsp.table_empty   = (count_next == '0);

    // Row write port: clearing pass or write back of the updated row.
    always_comb
    begin
        mem_wr   = 1'b0;
        kv_wr    = 1'b0;
        wr_addr  = job_reg.bucket[BKT_W-1:0];
        wr_valid = (rd_valid_reg | set_oh) & ~drop_oh;
        for (int w = 0; w < WAYS; w++)
        begin
            wr_key[w*KEY_W +: KEY_W] = set_oh[w] ? job_reg.req.key
                                                 : rd_key_reg[w*KEY_W +: KEY_W];
            wr_val[w*VAL_W +: VAL_W] = load_oh[w] ? job_reg.req.value_in
                                                  : rd_val_reg[w*VAL_W +: VAL_W];
        end
        if (state_reg == S_CLEAR)
        begin
            mem_wr   = 1'b1;
            wr_addr  = clr_idx_reg;
            wr_valid = '0;
        end
        else if (state_reg == S_UPDATE)
        begin
            mem_wr = 1'b1;
            kv_wr  = 1'b1;
        end
    end

    // Sequencer: clearing pass, then alternate read and update.
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (start)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_READ;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (state_reg == S_UPDATE)
            begin
                count_reg <= count_next;
            end
        end
    end

    // The job is held for its update cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= mid_job;
        end
    end

    // Bucket row memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            valid_mem[wr_addr] <= wr_valid;
        end
        if (kv_wr)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_key_reg   <= key_mem[rd_addr];
            rd_val_reg   <= val_mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/bucketed_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table core
// A key/value table of BUCKETS buckets with WAYS ways each; insert, remove and
// lookup requests go in through one queue face and results leave through another.
//
//   Channel   Handshake          Payload   Moves when
//   request   push / full        req       push high and full low
//   result    empty / pop        rsp       pop high and empty low
//
// The front takes a request every cycle while full is low, and spends two pipeline
// stages on the bucket index (reciprocal multiply, then one correction step).
// The back handles each request as a bucket row memory read, then the compare and
// row write back, and it takes no new request until that row is written back.
// A request with nothing ahead of it passes the front stages, the job queue, the
// back's row read and update and the result queue before it is on the result ports.
// After reset the back clears the valid bits one bucket row a cycle, over all
// BUCKETS rows, and full stays high during that pass.
// A result that is not popped holds its place; full rises once the job queue fills.
// ----------------------------------------------------------------------------
module bucketed_hash_table_core #(
    parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
    parameter int WAYS    = bht_pkg::WAYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  bht_pkg::req_t req,
    output logic          empty,
    input  logic          pop,
    output bht_pkg::rsp_t rsp
);

    localparam int MID_DEPTH = bht_pkg::MID_DEPTH;
    localparam int OUT_DEPTH = bht_pkg::OUT_DEPTH;
    localparam int JOB_W     = $bits(bht_pkg::job_t);
    localparam int RSP_W     = $bits(bht_pkg::rsp_t);

    logic                           mid_push;
    logic                           mid_pop;
    bht_pkg::job_t                  mid_wjob;
    bht_pkg::job_t                  mid_rjob;
    bht_pkg::qstat_t                mid_stat;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    bht_pkg::back_stat_t            back_stat;
    logic                           out_push;
    bht_pkg::rsp_t                  out_rsp;
    bht_pkg::qstat_t                out_stat;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    // Front: accept and bucket index.
    bht_front #(
        .BUCKETS   (BUCKETS),
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .mid_count (mid_count),
        .back_stat (back_stat),
        .mid_push  (mid_push),
        .mid_job   (mid_wjob)
    );

    // Queue of jobs between the front and the back.
    bht_queue #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wjob),
        .pop   (mid_pop),
        .rdata (mid_rjob),
        .stat  (mid_stat),
        .count (mid_count)
    );

    // Back: table memory and update.
    bht_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_job   (mid_rjob),
        .mid_stat  (mid_stat),
        .mid_pop   (mid_pop),
        .out_stat  (out_stat),
        .out_push  (out_push),
        .out_rsp   (out_rsp),
        .back_stat (back_stat)
    );

    // Result queue facing the consumer.
    bht_queue #(
        .WIDTH (RSP_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_rsp),
        .pop   (pop),
        .rdata (rsp),
        .stat  (out_stat),
        .count (out_count)
    );

    // The empty port follows the result queue's empty flag and its fill count.
    assign empty = out_stat.empty || (out_count == '0);

endmodule

@@ hw/rtl/bht_checker.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash table port checker
// Concurrent assertions on what the core's ports show over time, bound to
// the top level.
// ----------------------------------------------------------------------------
module bht_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          empty,
    input logic          pop,
    input bht_pkg::rsp_t rsp
);

    // A shown result carries one of the defined status codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.status == bht_pkg::STAT_INSERTED ||
                    rsp.status == bht_pkg::STAT_REPLACED ||
                    rsp.status == bht_pkg::STAT_REMOVED  ||
                    rsp.status == bht_pkg::STAT_NOTFOUND ||
                    rsp.status == bht_pkg::STAT_FULL     ||
                    rsp.status == bht_pkg::STAT_FOUND))
        else $error("result status code is undefined");

    // Only a successful lookup returns a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != bht_pkg::STAT_FOUND) |-> (rsp.value_out == '0))
        else $error("value returned outside a successful lookup");

    // Outcomes that prove an entry is held cannot report an empty table.
    a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (rsp.status == bht_pkg::STAT_INSERTED ||
                    rsp.status == bht_pkg::STAT_REPLACED ||
                    rsp.status == bht_pkg::STAT_FULL     ||
                    rsp.status == bht_pkg::STAT_FOUND)) |-> !rsp.table_empty)
        else $error("table reported empty although an entry is held");

    // A waiting result stays in place until it is popped.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("waiting result changed or vanished before pop");

endmodule

bind bucketed_hash_table_core bht_checker u_bht_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);
